### design/slr_pkg.sv
// Shared types, codes and constants for the sample log ring.
package slr_pkg;

  localparam int LogDepthDef = 16;

  localparam int OpW     = 2;
  localparam int SampleW = 10;
  localparam int ByteW   = 8;
  localparam int MsW     = 10;
  localparam int SecW    = 6;
  localparam int MinW    = 6;
  localparam int HourW   = 5;

  localparam logic [MsW-1:0] MsPerTickRst = MsW'(2);

  localparam int MsPerSecond = 1000;
  localparam int SecPerMin   = 60;
  localparam int MinPerHour  = 60;
  localparam int HoursPerDay = 24;

  localparam logic [ByteW-1:0] FrameData  = ByteW'(2);
  localparam logic [ByteW-1:0] FrameStamp = ByteW'(3);
  localparam logic [ByteW-1:0] StampRst   = ByteW'(255);

  typedef enum logic [OpW-1:0] {
    OP_TICK   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_DUMP   = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    SEL_HDR_DATA,
    SEL_LO,
    SEL_HI,
    SEL_HDR_STAMP,
    SEL_HOUR,
    SEL_MIN,
    SEL_SEC
  } byte_sel_e;

  typedef struct packed {
    logic      tick;
    logic      push;
    logic      pop;
    logic      rd_en;
    logic      load;
    byte_sel_e sel;
    logic      last;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic empty;
  } stat_t;

endpackage

### design/slr_if.sv
// Request channels of the sample log ring: input items, dump bytes, tick length writes.
interface slr_in_if;
  logic                        valid;
  logic                        ready;
  logic [slr_pkg::OpW-1:0]     opcode;
  logic [slr_pkg::SampleW-1:0] sample_value;

  modport source(output valid, output opcode, output sample_value, input ready);
  modport sink(input valid, input opcode, input sample_value, output ready);
endinterface

interface slr_out_if;
  logic                      valid;
  logic                      ready;
  logic [slr_pkg::ByteW-1:0] out_byte;
  logic                      last_byte;

  modport source(output valid, output out_byte, output last_byte, input ready);
  modport sink(input valid, input out_byte, input last_byte, output ready);
endinterface

interface slr_cfg_if;
  logic                    valid;
  logic                    ready;
  logic [slr_pkg::MsW-1:0] ms_per_tick;

  modport source(output valid, output ms_per_tick, input ready);
  modport sink(input valid, input ms_per_tick, output ready);
endinterface

### design/sample_log_ring_with_dump.sv
// Top level of the sample log ring: channel wiring, controller and datapath.
// Tick, sample and unused-opcode requests leave the state in S_IDLE, so ready stays high.
// A dump holds off input while 4 + 3*N bytes go out (N stored samples), one byte per cycle
// while the sink takes them; an accepted dump goes to S_CHK, which loads the first byte.
// The byte rate is set by the single output register that the dump sequencer fills.
// Reset (rst_ni low, asynchronous) empties the ring, zeroes the clock, sets the stamp to
// 255/255/255 and the tick length to 2 ms; the sample RAM contents are not cleared.
module sample_log_ring_with_dump #(
  parameter int LOG_DEPTH = slr_pkg::LogDepthDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  slr_in_if.sink     in_i,
  slr_out_if.source  out_o,
  slr_cfg_if.sink    cfg_i
);

  slr_pkg::cmd_t  cmd;
  slr_pkg::stat_t stat;

  assign cfg_i.ready = 1'b1;

  slr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .opcode_i  (in_i.opcode),
    .in_ready_o(in_i.ready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  slr_dp #(
    .LOG_DEPTH(LOG_DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .sample_value_i   (in_i.sample_value),
    .cfg_we_i         (cfg_i.valid),
    .cfg_ms_per_tick_i(cfg_i.ms_per_tick),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .out_byte_o       (out_o.out_byte),
    .last_byte_o      (out_o.last_byte)
  );

endmodule

### design/slr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module slr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/slr_ctrl.sv
// Controller: accepts input requests and sequences the dump byte stream.
module slr_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic [slr_pkg::OpW-1:0] opcode_i,
  output logic                    in_ready_o,
  input  slr_pkg::stat_t          stat_i,
  output slr_pkg::cmd_t           cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK,
    S_LO,
    S_HI,
    S_HOUR,
    S_MIN,
    S_SEC
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '{tick: 1'b0, push: 1'b0, pop: 1'b0, rd_en: 1'b0, load: 1'b0,
                sel: slr_pkg::SEL_HDR_DATA, last: 1'b0};
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (opcode_i)
            slr_pkg::OP_TICK:   cmd_o.tick = 1'b1;
            slr_pkg::OP_SAMPLE: cmd_o.push = 1'b1;
            slr_pkg::OP_DUMP:   state_d = S_CHK;
            default: ;
          endcase
        end
      end
      S_CHK: begin
        if (stat_i.slot_free) begin
          cmd_o.load = 1'b1;
          if (!stat_i.empty) begin
            // fetch the oldest entry while its header byte goes out
            cmd_o.rd_en = 1'b1;
            cmd_o.sel   = slr_pkg::SEL_HDR_DATA;
            state_d     = S_LO;
          end else begin
            cmd_o.sel = slr_pkg::SEL_HDR_STAMP;
            state_d   = S_HOUR;
          end
        end
      end
      S_LO: begin
        if (stat_i.slot_free) begin
          cmd_o.load = 1'b1;
          cmd_o.sel  = slr_pkg::SEL_LO;
          state_d    = S_HI;
        end
      end
      S_HI: begin
        if (stat_i.slot_free) begin
          cmd_o.load = 1'b1;
          cmd_o.sel  = slr_pkg::SEL_HI;
          cmd_o.pop  = 1'b1;
          state_d    = S_CHK;
        end
      end
      S_HOUR: begin
        if (stat_i.slot_free) begin
          cmd_o.load = 1'b1;
          cmd_o.sel  = slr_pkg::SEL_HOUR;
          state_d    = S_MIN;
        end
      end
      S_MIN: begin
        if (stat_i.slot_free) begin
          cmd_o.load = 1'b1;
          cmd_o.sel  = slr_pkg::SEL_MIN;
          state_d    = S_SEC;
        end
      end
      S_SEC: begin
        if (stat_i.slot_free) begin
          cmd_o.load = 1'b1;
          cmd_o.sel  = slr_pkg::SEL_SEC;
          cmd_o.last = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### design/slr_dp.sv
// Datapath: time-of-day clock, sample stamp, ring pointers, sample RAM, output register.
module slr_dp #(
  parameter int LOG_DEPTH = slr_pkg::LogDepthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  slr_pkg::cmd_t               cmd_i,
  output slr_pkg::stat_t              stat_o,
  input  logic [slr_pkg::SampleW-1:0] sample_value_i,
  input  logic                        cfg_we_i,
  input  logic [slr_pkg::MsW-1:0]     cfg_ms_per_tick_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [slr_pkg::ByteW-1:0]   out_byte_o,
  output logic                        last_byte_o
);

  localparam int IW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int CW = $clog2(LOG_DEPTH + 1);
  localparam int SW = CW + 1;

  // tick length
  logic [slr_pkg::MsW-1:0] ms_per_tick_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_per_tick_q <= slr_pkg::MsPerTickRst;
    end else if (cfg_we_i) begin
      ms_per_tick_q <= cfg_ms_per_tick_i;
    end
  end

  // time of day
  logic [slr_pkg::MsW-1:0]   millis_q, millis_d;
  logic [slr_pkg::SecW-1:0]  sec_q, sec_d;
  logic [slr_pkg::MinW-1:0]  min_q, min_d;
  logic [slr_pkg::HourW-1:0] hour_q, hour_d;
  logic [slr_pkg::MsW:0]     ms_sum;

  assign ms_sum = {1'b0, millis_q} + {1'b0, ms_per_tick_q};

  always_comb begin
    millis_d = millis_q;
    sec_d    = sec_q;
    min_d    = min_q;
    hour_d   = hour_q;
    if (cmd_i.tick) begin
      if (ms_sum >= (slr_pkg::MsW+1)'(slr_pkg::MsPerSecond)) begin
        // roll over to zero, not by subtracting a second
        millis_d = '0;
        if (sec_q == slr_pkg::SecW'(slr_pkg::SecPerMin - 1)) begin
          sec_d = '0;
          if (min_q == slr_pkg::MinW'(slr_pkg::MinPerHour - 1)) begin
            min_d = '0;
            if (hour_q == slr_pkg::HourW'(slr_pkg::HoursPerDay - 1)) begin
              hour_d = '0;
            end else begin
              hour_d = hour_q + 1'b1;
            end
          end else begin
            min_d = min_q + 1'b1;
          end
        end else begin
          sec_d = sec_q + 1'b1;
        end
      end else begin
        millis_d = ms_sum[slr_pkg::MsW-1:0];
      end
    end
  end

  // stamp of the last sample
  logic [slr_pkg::ByteW-1:0] stamp_hour_q, stamp_min_q, stamp_sec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      millis_q     <= '0;
      sec_q        <= '0;
      min_q        <= '0;
      hour_q       <= '0;
      stamp_hour_q <= slr_pkg::StampRst;
      stamp_min_q  <= slr_pkg::StampRst;
      stamp_sec_q  <= slr_pkg::StampRst;
    end else begin
      millis_q <= millis_d;
      sec_q    <= sec_d;
      min_q    <= min_d;
      hour_q   <= hour_d;
      if (cmd_i.push) begin
        stamp_hour_q <= slr_pkg::ByteW'(hour_q);
        stamp_min_q  <= slr_pkg::ByteW'(min_q);
        stamp_sec_q  <= slr_pkg::ByteW'(sec_q);
      end
    end
  end

  // ring pointers
  logic [IW-1:0] oldest_q, oldest_d, oldest_next, wr_idx;
  logic [CW-1:0] count_q, count_d;
  logic [SW-1:0] wr_sum;
  logic          full;

  assign full        = (count_q == CW'(LOG_DEPTH));
  assign oldest_next = (oldest_q == IW'(LOG_DEPTH - 1)) ? '0 : oldest_q + 1'b1;

  always_comb begin
    wr_sum = SW'(oldest_q) + SW'(count_q);
    if (wr_sum >= SW'(LOG_DEPTH)) begin
      wr_sum = wr_sum - SW'(LOG_DEPTH);
    end
    wr_idx = full ? oldest_q : wr_sum[IW-1:0];
  end

  always_comb begin
    oldest_d = oldest_q;
    count_d  = count_q;
    if (cmd_i.push) begin
      if (full) begin
        // overwrite the oldest entry
        oldest_d = oldest_next;
      end else begin
        count_d = count_q + 1'b1;
      end
    end else if (cmd_i.pop) begin
      oldest_d = oldest_next;
      count_d  = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q <= '0;
      count_q  <= '0;
    end else begin
      oldest_q <= oldest_d;
      count_q  <= count_d;
    end
  end

  logic [slr_pkg::SampleW-1:0] rdata;

  slr_ram #(
    .WIDTH(slr_pkg::SampleW),
    .DEPTH(LOG_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.push),
    .waddr_i(wr_idx),
    .wdata_i(sample_value_i),
    .re_i   (cmd_i.rd_en),
    .raddr_i(oldest_q),
    .rdata_o(rdata)
  );

  // output register
  logic                      out_valid_q;
  logic [slr_pkg::ByteW-1:0] out_byte_q, byte_mux;
  logic                      out_last_q;

  always_comb begin
    case (cmd_i.sel)
      slr_pkg::SEL_HDR_DATA:  byte_mux = slr_pkg::FrameData;
      slr_pkg::SEL_LO:        byte_mux = rdata[7:0];
      slr_pkg::SEL_HI:        byte_mux = slr_pkg::ByteW'(rdata[slr_pkg::SampleW-1:8]);
      slr_pkg::SEL_HDR_STAMP: byte_mux = slr_pkg::FrameStamp;
      slr_pkg::SEL_HOUR:      byte_mux = stamp_hour_q;
      slr_pkg::SEL_MIN:       byte_mux = stamp_min_q;
      slr_pkg::SEL_SEC:       byte_mux = stamp_sec_q;
      default:                byte_mux = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_byte_q <= byte_mux;
      out_last_q <= cmd_i.last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = out_byte_q;
  assign last_byte_o      = out_last_q;
  assign stat_o.slot_free = !out_valid_q || out_ready_i;
  assign stat_o.empty     = (count_q == '0);

endmodule

### design/slr_checker.sv
// Port-level assertions for the sample log ring, bound to the top level.
module slr_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic [slr_pkg::OpW-1:0]   in_opcode_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [slr_pkg::ByteW-1:0] out_byte_i,
  input logic                      last_byte_i
);

  // a stalled byte holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) && $stable(last_byte_i))
    else $error("dump byte changed while stalled");

  // input stays blocked while a dump is mid-stream
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_byte_i |-> !in_ready_i)
    else $error("input accepted during a dump");

  // an accepted dump blocks input on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_opcode_i == slr_pkg::OP_DUMP) |=> !in_ready_i)
    else $error("dump did not start");

  // non-dump requests leave input ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_opcode_i != slr_pkg::OP_DUMP) |=> in_ready_i)
    else $error("non-dump request stalled input");

endmodule

bind sample_log_ring_with_dump slr_checker u_slr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .in_opcode_i(in_i.opcode),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_byte_i (out_o.out_byte),
  .last_byte_i(out_o.last_byte)
);

### test/tb.sv
// Testbench for the sample log ring: directed table, random phases and a minute-wrap tick run.
`timescale 1ns / 100ps

module tb;

  localparam int OpW     = slr_pkg::OpW;
  localparam int SampleW = slr_pkg::SampleW;
  localparam int ByteW   = slr_pkg::ByteW;
  localparam int MsW     = slr_pkg::MsW;
  localparam int Depth   = slr_pkg::LogDepthDef;

  localparam logic [OpW-1:0] OpUnused = 2'd3;
  localparam int IdlePct = 23;
  localparam int HoldCycles = 300;
  localparam int DrainCycles = 4;
  localparam int PhaseItems = 35;
  localparam int MinuteTicks = 62;

  localparam logic [7*ByteW-1:0] RstStampDump =
    {slr_pkg::FrameStamp, {3{slr_pkg::StampRst}}, 24'd0};
  localparam logic [7*ByteW-1:0] MaxSampleDump =
    {slr_pkg::FrameData, 8'hFF, 8'h03, slr_pkg::FrameStamp, 24'd0};

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } dump_byte_t;

  typedef struct {
    logic                is_cfg;
    logic [OpW-1:0]      op;
    logic [SampleW-1:0]  val;
    int                  n_known;
    logic [7*ByteW-1:0]  known;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  slr_in_if  in_ch();
  slr_out_if out_ch();
  slr_cfg_if cfg_ch();

  sample_log_ring_with_dump uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  always #10 clk_i = ~clk_i;

  // Mirror of the block state
  logic [SampleW-1:0]           ring_mem [Depth];
  int                           ring_head = 0;
  int                           ring_fill = 0;
  logic [MsW-1:0]               tick_len = slr_pkg::MsPerTickRst;
  logic [MsW-1:0]               clk_ms = '0;
  logic [slr_pkg::SecW-1:0]     clk_sec = '0;
  logic [slr_pkg::MinW-1:0]     clk_min = '0;
  logic [slr_pkg::HourW-1:0]    clk_hr = '0;
  logic [ByteW-1:0]             st_hr = slr_pkg::StampRst;
  logic [ByteW-1:0]             st_min = slr_pkg::StampRst;
  logic [ByteW-1:0]             st_sec = slr_pkg::StampRst;

  dump_byte_t predicted[$];
  dump_byte_t dump_q[$];

  int errors = 0;
  int items_sent = 0;
  int tx_idle_pct = IdlePct;
  int rx_idle_pct = IdlePct;
  int hold_reqs = 0;

  stim_row_t dir_tab [22] = '{
    '{1'b0, slr_pkg::OP_DUMP, 10'd0, 4, RstStampDump},
    '{1'b0, OpUnused, 10'h3FF, 0, '0},
    '{1'b0, slr_pkg::OP_DUMP, 10'h3FF, 4, RstStampDump},
    '{1'b0, slr_pkg::OP_SAMPLE, 10'h3FF, 0, '0},
    '{1'b0, slr_pkg::OP_DUMP, 10'd0, 7, MaxSampleDump},
    '{1'b0, slr_pkg::OP_SAMPLE, 10'd0, 0, '0},
    '{1'b0, slr_pkg::OP_SAMPLE, 10'h2AA, 0, '0},
    '{1'b0, slr_pkg::OP_DUMP, 10'h155, 0, '0},
    '{1'b1, slr_pkg::OP_TICK, 10'd999, 0, '0},
    '{1'b0, slr_pkg::OP_TICK, 10'h155, 0, '0},
    '{1'b0, slr_pkg::OP_TICK, 10'h2AA, 0, '0},
    '{1'b0, slr_pkg::OP_TICK, 10'd0, 0, '0},
    '{1'b0, slr_pkg::OP_SAMPLE, 10'h155, 0, '0},
    '{1'b0, slr_pkg::OP_DUMP, 10'd0, 0, '0},
    '{1'b1, slr_pkg::OP_TICK, 10'd0, 0, '0},
    '{1'b0, slr_pkg::OP_TICK, 10'h3FF, 0, '0},
    '{1'b0, slr_pkg::OP_SAMPLE, 10'd1, 0, '0},
    '{1'b0, slr_pkg::OP_DUMP, 10'd0, 0, '0},
    '{1'b1, slr_pkg::OP_TICK, 10'd1023, 0, '0},
    '{1'b0, slr_pkg::OP_TICK, 10'd0, 0, '0},
    '{1'b0, slr_pkg::OP_SAMPLE, 10'd512, 0, '0},
    '{1'b0, slr_pkg::OP_DUMP, 10'd0, 0, '0}
  };

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= 50) begin
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    end
  endtask

  // Work out the dump bytes one request causes and advance the mirror state.
  function automatic void predict_item(input logic [OpW-1:0] op, input logic [SampleW-1:0] val);
    int               sum;
    int               slot;
    logic [SampleW-1:0] v;
    predicted.delete();
    case (op)
      slr_pkg::OP_TICK: begin
        sum = int'(clk_ms) + int'(tick_len);
        if (sum >= slr_pkg::MsPerSecond) begin
          clk_ms = '0;
          if (int'(clk_sec) + 1 >= slr_pkg::SecPerMin) begin
            clk_sec = '0;
            if (int'(clk_min) + 1 >= slr_pkg::MinPerHour) begin
              clk_min = '0;
              if (int'(clk_hr) + 1 >= slr_pkg::HoursPerDay) clk_hr = '0;
              else clk_hr = clk_hr + 1'b1;
            end else begin
              clk_min = clk_min + 1'b1;
            end
          end else begin
            clk_sec = clk_sec + 1'b1;
          end
        end else begin
          clk_ms = MsW'(sum);
        end
      end
      slr_pkg::OP_SAMPLE: begin
        if (ring_fill < Depth) begin
          slot = (ring_head + ring_fill) % Depth;
          ring_mem[slot] = val;
          ring_fill++;
        end else begin
          // Full: overwrite the oldest entry
          ring_mem[ring_head] = val;
          ring_head = (ring_head + 1) % Depth;
        end
        st_hr  = ByteW'(clk_hr);
        st_min = ByteW'(clk_min);
        st_sec = ByteW'(clk_sec);
      end
      slr_pkg::OP_DUMP: begin
        while (ring_fill > 0) begin
          v = ring_mem[ring_head];
          ring_head = (ring_head + 1) % Depth;
          ring_fill--;
          predicted.push_back('{slr_pkg::FrameData, 1'b0});
          predicted.push_back('{v[7:0], 1'b0});
          predicted.push_back('{{6'b0, v[9:8]}, 1'b0});
        end
        predicted.push_back('{slr_pkg::FrameStamp, 1'b0});
        predicted.push_back('{st_hr, 1'b0});
        predicted.push_back('{st_min, 1'b0});
        predicted.push_back('{st_sec, 1'b1});
      end
      default: ;
    endcase
  endfunction

  // Offer one request, wait for its handshake, then queue what it should produce.
  task automatic send_item(input logic [OpW-1:0] op, input logic [SampleW-1:0] val,
                           input int n_known, input logic [7*ByteW-1:0] known);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.sample_value <= val;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_item(op, val);
    if (op != OpUnused) items_sent++;
    if (n_known > 0) begin
      for (int k = 0; k < n_known; k++) begin
        dump_q.push_back('{known[7*ByteW-1-ByteW*k -: ByteW], k == n_known - 1});
      end
    end else begin
      foreach (predicted[k]) dump_q.push_back(predicted[k]);
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (dump_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_tick_len(input logic [MsW-1:0] len);
    drain_results();
    cfg_ch.valid       <= 1'b1;
    cfg_ch.ms_per_tick <= len;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    tick_len = len;
  endtask

  // Mostly runs of samples and ticks closed by a dump; some loose requests.
  task automatic send_random_burst();
    int n;
    if ($urandom_range(99) < 70) begin
      n = $urandom_range(0, 20);
      for (int j = 0; j < n; j++) begin
        if ($urandom_range(99) < 40) send_item(slr_pkg::OP_TICK, 10'($urandom), 0, '0);
        else send_item(slr_pkg::OP_SAMPLE, 10'($urandom), 0, '0);
      end
      send_item(slr_pkg::OP_DUMP, 10'($urandom), 0, '0);
    end else begin
      send_item(2'($urandom_range(3)), 10'($urandom), 0, '0);
    end
  endtask

  // Receiver: check bytes, stall at random, hold off on request
  initial begin : byte_sink
    dump_byte_t want;
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        if (dump_q.size() == 0) begin
          report_mismatch("byte with nothing pending", out_ch.out_byte, -1);
        end else begin
          want = dump_q.pop_front();
          if (out_ch.out_byte !== want.data)
            report_mismatch("out_byte", out_ch.out_byte, want.data);
          if (out_ch.last_byte !== want.last)
            report_mismatch("last_byte", out_ch.last_byte, want.last);
        end
      end
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin : stimulus
    logic [MsW-1:0] phase_len [6];
    in_ch.valid        <= 1'b0;
    in_ch.opcode       <= slr_pkg::OP_TICK;
    in_ch.sample_value <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.ms_per_tick <= slr_pkg::MsPerTickRst;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) write_tick_len(dir_tab[i].val);
      else send_item(dir_tab[i].op, dir_tab[i].val, dir_tab[i].n_known, dir_tab[i].known);
    end

    // Fill past capacity, then hold the sink off while requests keep coming
    write_tick_len(10'd7);
    for (int j = 0; j < Depth + 3; j++) send_item(slr_pkg::OP_SAMPLE, 10'($urandom), 0, '0);
    hold_reqs <= hold_reqs + 1;
    send_item(slr_pkg::OP_DUMP, 10'($urandom), 0, '0);
    for (int j = 0; j < 10; j++) send_item(2'($urandom_range(1)), 10'($urandom), 0, '0);
    send_item(slr_pkg::OP_DUMP, 10'($urandom), 0, '0);

    phase_len = '{10'd1, 10'd999, 10'd0, 10'd1023, 10'($urandom_range(1, 999)),
                  slr_pkg::MsPerTickRst};
    foreach (phase_len[p]) begin
      write_tick_len(phase_len[p]);
      if (p == 2) begin
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
      end else begin
        tx_idle_pct <= IdlePct;
        rx_idle_pct <= IdlePct;
      end
      items_sent = 0;
      while (items_sent < PhaseItems) send_random_burst();
    end
    tx_idle_pct <= IdlePct;
    rx_idle_pct <= IdlePct;

    // One second per tick: run the clock past a minute wrap
    write_tick_len(10'd1023);
    for (int t = 0; t < MinuteTicks; t++) begin
      send_item(slr_pkg::OP_TICK, 10'($urandom), 0, '0);
      if (t % 20 == 10) send_item(slr_pkg::OP_SAMPLE, 10'($urandom), 0, '0);
      if (t == 45) send_item(slr_pkg::OP_DUMP, 10'($urandom), 0, '0);
    end
    send_item(slr_pkg::OP_SAMPLE, 10'($urandom), 0, '0);
    send_item(slr_pkg::OP_DUMP, 10'($urandom), 0, '0);

    drain_results();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### files.f
design/slr_pkg.sv
design/slr_if.sv
design/slr_ram.sv
design/slr_ctrl.sv
design/slr_dp.sv
design/sample_log_ring_with_dump.sv
design/slr_checker.sv
test/tb.sv
